/* hw/rtl/rpy2ov_pkg.sv */
package rpy2ov_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanEntries = 24;
  localparam int CordicSteps = (CordicIterations > AtanEntries) ? AtanEntries
                                                                 : CordicIterations;

  localparam int InW = 16;
  localparam int OutW = 16;
  localparam int AngW = 28;
  localparam int TrigW = 32;
  localparam int ProdW = 34;
  localparam int SumW = ProdW + 1;
  localparam int FullW = ProdW + TrigW;
  localparam int AngShift = 11;
  localparam int NumLanes = 3;

  localparam int LaneRoll = 0;
  localparam int LanePitch = 1;
  localparam int LaneYaw = 2;

  typedef logic signed [AngW-1:0] angle_t;
  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0] sum_t;

  localparam angle_t AngPi = 28'sd52707179;
  localparam angle_t AngHalfPi = 28'sd26353589;
  localparam trig_t GainQ30 = 32'sd652032874;

  localparam logic signed [SumW-16:0] UnitQ14 = 20'sd16384;
  localparam logic signed [SumW-16:0] NegUnitQ14 = -20'sd16384;

  typedef struct packed {
    logic signed [InW-1:0] roll;
    logic signed [InW-1:0] pitch;
    logic signed [InW-1:0] yaw;
  } rpy_t;

  typedef struct packed {
    logic signed [OutW-1:0] x_axis_i;
    logic signed [OutW-1:0] x_axis_j;
    logic signed [OutW-1:0] x_axis_k;
    logic signed [OutW-1:0] z_axis_i;
    logic signed [OutW-1:0] z_axis_j;
    logic signed [OutW-1:0] z_axis_k;
  } axes_t;

  function automatic angle_t atan_q24(input int idx);
    case (idx)
      0: atan_q24 = 28'sd13176795;
      1: atan_q24 = 28'sd7778716;
      2: atan_q24 = 28'sd4110060;
      3: atan_q24 = 28'sd2086331;
      4: atan_q24 = 28'sd1047214;
      5: atan_q24 = 28'sd524117;
      6: atan_q24 = 28'sd262123;
      7: atan_q24 = 28'sd131069;
      8: atan_q24 = 28'sd65536;
      9: atan_q24 = 28'sd32768;
      10: atan_q24 = 28'sd16384;
      11: atan_q24 = 28'sd8192;
      12: atan_q24 = 28'sd4096;
      13: atan_q24 = 28'sd2048;
      14: atan_q24 = 28'sd1024;
      15: atan_q24 = 28'sd512;
      16: atan_q24 = 28'sd256;
      17: atan_q24 = 28'sd128;
      18: atan_q24 = 28'sd64;
      19: atan_q24 = 28'sd32;
      20: atan_q24 = 28'sd16;
      21: atan_q24 = 28'sd8;
      22: atan_q24 = 28'sd4;
      23: atan_q24 = 28'sd2;
      default: atan_q24 = 28'sd0;
    endcase
  endfunction

  function automatic prod_t mul_q30(input prod_t a, input trig_t b);
    logic signed [FullW-1:0] p;
    p = a * b + $signed({1'b0, 1'b1, 29'b0});
    mul_q30 = p[ProdW+29:30];
  endfunction

  function automatic logic signed [OutW-1:0] to_q14(input sum_t v);
    sum_t t;
    logic signed [SumW-16:0] r;
    t = v + $signed({1'b0, 1'b1, 15'b0});
    r = {t[SumW-1], t[SumW-1:16]};
    if (r > UnitQ14) begin
      to_q14 = OutW'(UnitQ14);
    end else if (r < NegUnitQ14) begin
      to_q14 = OutW'(NegUnitQ14);
    end else begin
      to_q14 = OutW'(r);
    end
  endfunction

endpackage

/* hw/rtl/rpy_to_orientation_vectors_core.sv */
// Converts roll, pitch and yaw angles into the x and z axis columns of the
// ZYX rotation matrix.
// The input channel carries one angle triple per transfer in signed Q3.13
// radians; the output channel carries six signed Q1.14 components per transfer.
// Both channels use valid and stall, and a transfer happens on a rising edge
// with valid high and stall low.
// The pipeline consists of quadrant folding, the 16 CORDIC steps, the final
// sign correction, two multiplier stages and one output rounding stage.
// Throughput is one transfer per cycle while the receiver does not stall, set
// by the fully unrolled CORDIC lanes.
// When the receiver stalls while a result waits, the whole pipeline holds and
// in_stall_o rises in the same cycle, so no item is lost or repeated.
// Reset clears all valid bits, so the block comes out of reset empty and
// ready to accept an item.
module rpy_to_orientation_vectors_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rpy2ov_pkg::rpy_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rpy2ov_pkg::axes_t    out_data_o
);
  import rpy2ov_pkg::*;

  logic  en;
  logic  trig_valid;
  trig_t sin_w [NumLanes];
  trig_t cos_w [NumLanes];

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  rpy2ov_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .rpy_i   (in_data_i),
    .valid_o (trig_valid),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  rpy2ov_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trig_valid),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .valid_o (out_valid_o),
    .axes_o  (out_data_o)
  );

endmodule

/* hw/rtl/rpy2ov_cordic.sv */
module rpy2ov_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rpy2ov_pkg::rpy_t     rpy_i,
  output logic                 valid_o,
  output rpy2ov_pkg::trig_t    sin_o [rpy2ov_pkg::NumLanes],
  output rpy2ov_pkg::trig_t    cos_o [rpy2ov_pkg::NumLanes]
);
  import rpy2ov_pkg::*;

  logic signed [InW-1:0] ang [NumLanes];
  angle_t z_in [NumLanes];
  angle_t z_pre [NumLanes];
  logic   flip_pre [NumLanes];

  logic [CordicSteps+1:0] vld_q;
  trig_t  x_q [CordicSteps+1][NumLanes];
  trig_t  y_q [CordicSteps+1][NumLanes];
  angle_t z_q [CordicSteps][NumLanes];
  logic   flip_q [CordicSteps+1][NumLanes];
  trig_t  sin_q [NumLanes];
  trig_t  cos_q [NumLanes];

  assign ang[LaneRoll] = rpy_i.roll;
  assign ang[LanePitch] = rpy_i.pitch;
  assign ang[LaneYaw] = rpy_i.yaw;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      z_in[l] = {{(AngW-InW-AngShift){ang[l][InW-1]}}, ang[l], {AngShift{1'b0}}};
      if (z_in[l] > AngHalfPi) begin
        z_pre[l] = z_in[l] - AngPi;
        flip_pre[l] = 1'b1;
      end else if (z_in[l] < -AngHalfPi) begin
        z_pre[l] = z_in[l] + AngPi;
        flip_pre[l] = 1'b1;
      end else begin
        z_pre[l] = z_in[l];
        flip_pre[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CordicSteps:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        x_q[0][l] <= GainQ30;
        y_q[0][l] <= '0;
        z_q[0][l] <= z_pre[l];
        flip_q[0][l] <= flip_pre[l];
      end
    end
  end

  for (genvar s = 0; s < CordicSteps; s++) begin : g_step
    trig_t  nx [NumLanes];
    trig_t  ny [NumLanes];

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        if (z_q[s][l] >= 0) begin
          nx[l] = x_q[s][l] - (y_q[s][l] >>> s);
          ny[l] = y_q[s][l] + (x_q[s][l] >>> s);
        end else begin
          nx[l] = x_q[s][l] + (y_q[s][l] >>> s);
          ny[l] = y_q[s][l] - (x_q[s][l] >>> s);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < NumLanes; l++) begin
          x_q[s+1][l] <= nx[l];
          y_q[s+1][l] <= ny[l];
          flip_q[s+1][l] <= flip_q[s][l];
        end
      end
    end

    if (s + 1 < CordicSteps) begin : g_z
      angle_t nz [NumLanes];

      always_comb begin
        for (int l = 0; l < NumLanes; l++) begin
          if (z_q[s][l] >= 0) begin
            nz[l] = z_q[s][l] - atan_q24(s);
          end else begin
            nz[l] = z_q[s][l] + atan_q24(s);
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          for (int l = 0; l < NumLanes; l++) begin
            z_q[s+1][l] <= nz[l];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        if (flip_q[CordicSteps][l]) begin
          sin_q[l] <= -y_q[CordicSteps][l];
          cos_q[l] <= -x_q[CordicSteps][l];
        end else begin
          sin_q[l] <= y_q[CordicSteps][l];
          cos_q[l] <= x_q[CordicSteps][l];
        end
      end
    end
  end

  assign valid_o = vld_q[CordicSteps+1];
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* hw/rtl/rpy2ov_matrix.sv */
module rpy2ov_matrix (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rpy2ov_pkg::trig_t    sin_i [rpy2ov_pkg::NumLanes],
  input  rpy2ov_pkg::trig_t    cos_i [rpy2ov_pkg::NumLanes],
  output logic                 valid_o,
  output rpy2ov_pkg::axes_t    axes_o
);
  import rpy2ov_pkg::*;

  logic [2:0] vld_q;

  prod_t cy_cp_q, sy_cp_q, cy_sp_q, sy_sp_q, sy_sr_q, cy_sr_q, cp_cr_q, nsp_q;
  trig_t cr_q;

  prod_t cy_cp_b_q, sy_cp_b_q, cysp_cr_q, sysp_cr_q, sy_sr_b_q, cy_sr_b_q;
  prod_t cp_cr_b_q, nsp_b_q;

  axes_t axes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cy_cp_q <= mul_q30(ProdW'(cos_i[LaneYaw]), cos_i[LanePitch]);
      sy_cp_q <= mul_q30(ProdW'(sin_i[LaneYaw]), cos_i[LanePitch]);
      cy_sp_q <= mul_q30(ProdW'(cos_i[LaneYaw]), sin_i[LanePitch]);
      sy_sp_q <= mul_q30(ProdW'(sin_i[LaneYaw]), sin_i[LanePitch]);
      sy_sr_q <= mul_q30(ProdW'(sin_i[LaneYaw]), sin_i[LaneRoll]);
      cy_sr_q <= mul_q30(ProdW'(cos_i[LaneYaw]), sin_i[LaneRoll]);
      cp_cr_q <= mul_q30(ProdW'(cos_i[LanePitch]), cos_i[LaneRoll]);
      nsp_q <= -ProdW'(sin_i[LanePitch]);
      cr_q <= cos_i[LaneRoll];

      cy_cp_b_q <= cy_cp_q;
      sy_cp_b_q <= sy_cp_q;
      cysp_cr_q <= mul_q30(cy_sp_q, cr_q);
      sysp_cr_q <= mul_q30(sy_sp_q, cr_q);
      sy_sr_b_q <= sy_sr_q;
      cy_sr_b_q <= cy_sr_q;
      cp_cr_b_q <= cp_cr_q;
      nsp_b_q <= nsp_q;

      axes_q.x_axis_i <= to_q14(SumW'(cy_cp_b_q));
      axes_q.x_axis_j <= to_q14(SumW'(sy_cp_b_q));
      axes_q.x_axis_k <= to_q14(SumW'(nsp_b_q));
      axes_q.z_axis_i <= to_q14(SumW'(cysp_cr_q) + SumW'(sy_sr_b_q));
      axes_q.z_axis_j <= to_q14(SumW'(sysp_cr_q) - SumW'(cy_sr_b_q));
      axes_q.z_axis_k <= to_q14(SumW'(cp_cr_b_q));
    end
  end

  assign valid_o = vld_q[2];
  assign axes_o = axes_q;

endmodule
